### hdl/lsp_pkg.sv
// ============================================================================
// lsp_pkg
// Shared types and constants for the bounded LIFO stack with palindrome check.
// ============================================================================
package lsp_pkg;

  // Stack geometry
  localparam int DEPTH = 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = 32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_DUMP  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESULT,
    S_POP_WAIT,
    S_CHK_RD,
    S_CHK_CMP,
    S_DMP_RD,
    S_DMP_OUT
  } fsm_state_t;

  typedef struct packed {
    command_t               command;
    logic signed [WW-1:0]   push_value;
  } lsp_in_t;

  typedef struct packed {
    status_t                status;
    logic signed [WW-1:0]   data_word;
    logic                   is_palindrome;
    logic [3:0]             fill_level;
    logic                   last;
  } lsp_out_t;

endpackage

### hdl/lifo_stack_with_palindrome_check.sv
// ============================================================================
// lifo_stack_with_palindrome_check
// Bounded LIFO stack of signed words with palindrome check and dump.
// ============================================================================
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_data) carries one command per
//   transfer: push, pop, palindrome check or dump. res channel
//   (res_valid/res_ready/res_data) returns the results; the final result of
//   each command has last set. Push, pop and check give one result each, a
//   dump gives one result per held word, top first (one empty result if the
//   stack holds nothing).
//   Commands are handled one at a time; cmd_ready is high when the block is
//   between commands. The words sit in a memory with registered read data;
//   check and dump cost one read plus one compare or output step per pair
//   or word.
//   Reset empties the stack and drops any pending result. When the receiver
//   stalls, the result holds in the output register and the sequencer waits.
// ============================================================================
module lifo_stack_with_palindrome_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  lsp_pkg::lsp_in_t  cmd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output lsp_pkg::lsp_out_t res_data
);
  import lsp_pkg::*;

  fsm_state_t        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     lo, lo_next;
  logic [AW-1:0]     hi, hi_next;
  status_t           res_status, res_status_next;
  logic              res_pal, res_pal_next;

  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     rd_addr_a;
  logic signed [WW-1:0] rd_data_a, rd_data_b;

  logic              slot_free;
  logic              load;
  lsp_out_t          load_data;
  logic [AW:0]       span;

  lsp_mem u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(count)),
    .wr_data   (cmd_data.push_value),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (hi),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign slot_free = !res_valid || res_ready;
  assign span      = (AW+1)'(hi) - (AW+1)'(lo);

  // Sequence commands
  always_comb begin
    state_next      = state;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    res_status_next = res_status;
    res_pal_next    = res_pal;
    cmd_ready       = (state == S_IDLE);
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr_a       = lo;
    load            = 1'b0;
    load_data       = '0;
    load_data.fill_level = 4'(count);

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          res_status_next = ST_OK;
          res_pal_next    = 1'b0;
          unique case (cmd_data.command)
            CMD_PUSH: begin
              if (count >= CW'(DEPTH)) begin
                res_status_next = ST_OVERFLOW;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
              state_next = S_RESULT;
            end
            CMD_POP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_RESULT;
              end else begin
                count_next = count - CW'(1);
                rd_en      = 1'b1;
                rd_addr_a  = AW'(count - CW'(1));
                state_next = S_POP_WAIT;
              end
            end
            CMD_CHECK: begin
              if (count <= CW'(1)) begin
                res_pal_next = 1'b1;
                state_next   = S_RESULT;
              end else begin
                lo_next    = '0;
                hi_next    = AW'(count - CW'(1));
                state_next = S_CHK_RD;
              end
            end
            CMD_DUMP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_RESULT;
              end else begin
                hi_next    = AW'(count - CW'(1));
                state_next = S_DMP_RD;
              end
            end
          endcase
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          load                    = 1'b1;
          load_data.status        = res_status;
          load_data.is_palindrome = res_pal;
          load_data.last          = 1'b1;
          state_next              = S_IDLE;
        end
      end
      S_POP_WAIT: begin
        if (slot_free) begin
          load                = 1'b1;
          load_data.status    = ST_OK;
          load_data.data_word = rd_data_a;
          load_data.last      = 1'b1;
          state_next          = S_IDLE;
        end
      end
      S_CHK_RD: begin
        rd_en      = 1'b1;
        state_next = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (rd_data_a != rd_data_b) begin
          res_pal_next = 1'b0;
          state_next   = S_RESULT;
        end else if (span <= (AW+1)'(2)) begin
          res_pal_next = 1'b1;
          state_next   = S_RESULT;
        end else begin
          lo_next    = lo + AW'(1);
          hi_next    = hi - AW'(1);
          state_next = S_CHK_RD;
        end
      end
      S_DMP_RD: begin
        rd_en      = 1'b1;
        rd_addr_a  = hi;
        state_next = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        if (slot_free) begin
          load                = 1'b1;
          load_data.status    = ST_OK;
          load_data.data_word = rd_data_a;
          load_data.last      = (hi == '0);
          if (hi == '0) begin
            state_next = S_IDLE;
          end else begin
            hi_next    = hi - AW'(1);
            state_next = S_DMP_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    res_status <= res_status_next;
    res_pal    <= res_pal_next;
  end

  // Output valid: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= load_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stack count above depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == ST_OVERFLOW |-> res_data.fill_level == 4'(DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_data.command == CMD_POP && count != '0
    |=> count == $past(count) - CW'(1))
    else $error("pop did not drop the count by one");

  a_check_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK_CMP |-> lo < hi)
    else $error("palindrome pointers crossed");
`endif

endmodule

### hdl/lsp_mem.sv
// ============================================================================
// lsp_mem
// Stack word storage: one write port and two read ports with registered data.
// ============================================================================
module lsp_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [lsp_pkg::AW-1:0]        wr_addr,
  input  logic signed [lsp_pkg::WW-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [lsp_pkg::AW-1:0]        rd_addr_a,
  input  logic [lsp_pkg::AW-1:0]        rd_addr_b,
  output logic signed [lsp_pkg::WW-1:0] rd_data_a,
  output logic signed [lsp_pkg::WW-1:0] rd_data_b
);
  import lsp_pkg::*;

  logic signed [WW-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read two words, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

### tb/lifo_stack_with_palindrome_check_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// lifo_stack_with_palindrome_check_tb
// Self-checking bench for the bounded LIFO stack. Commands go in over the
// cmd channel, and a local copy of the stack predicts every result they
// cause. Each result transfer is checked field by field against the oldest
// prediction. Directed cases cover the empty and full corners first. Random
// mixes, palindrome build-and-check runs and a long receiver hold follow.
// Both sides idle at random in the random mixes; the palindrome runs turn each side's idling on or off at random.
// ============================================================================
module lifo_stack_with_palindrome_check_tb;
  import lsp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_ready;
  lsp_in_t  cmd_data  = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  lsp_out_t res_data;

  // Predicted stack contents and the results still owed by the block
  logic [WW-1:0] stack_words [DEPTH];
  int            stack_fill;
  lsp_out_t      owed_results [$];

  int   mismatch_count;
  int   cycle_count;
  logic tx_gaps_on   = 1'b0;
  logic rx_stalls_on = 1'b0;
  int   hold_ticket;
  int   hold_served;
  int   hold_left;
  int   stall_left;

  lifo_stack_with_palindrome_check u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lifo_stack_with_palindrome_check] ERROR");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input logic enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(25, 50);
  endfunction

  // Word source biased toward corners and repeats
  function automatic logic [WW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(WW-1){1'b0}}};
      3: return {1'b0, {(WW-1){1'b1}}};
      4, 5: return WW'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic lsp_out_t make_result(input status_t st, input logic [WW-1:0] word,
                                           input logic pal, input logic fin);
    lsp_out_t r;
    r.status        = st;
    r.data_word     = word;
    r.is_palindrome = pal;
    r.fill_level    = 4'(stack_fill);
    r.last          = fin;
    return r;
  endfunction

  // Compare mirrored pairs from both ends inward
  function automatic logic contents_symmetric();
    int lo;
    int hi;
    lo = 0;
    hi = stack_fill - 1;
    while (lo < hi) begin
      if (stack_words[lo] != stack_words[hi]) return 1'b0;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  // Apply one command to the local stack and queue the results it owes
  task automatic predict_command(input lsp_in_t item);
    int i;
    case (item.command)
      CMD_PUSH: begin
        if (stack_fill >= DEPTH) begin
          owed_results.push_back(make_result(ST_OVERFLOW, '0, 1'b0, 1'b1));
        end else begin
          stack_words[stack_fill] = item.push_value;
          stack_fill++;
          owed_results.push_back(make_result(ST_OK, '0, 1'b0, 1'b1));
        end
      end
      CMD_POP: begin
        if (stack_fill == 0) begin
          owed_results.push_back(make_result(ST_EMPTY, '0, 1'b0, 1'b1));
        end else begin
          stack_fill--;
          owed_results.push_back(make_result(ST_OK, stack_words[stack_fill], 1'b0, 1'b1));
        end
      end
      CMD_CHECK: begin
        owed_results.push_back(make_result(ST_OK, '0, contents_symmetric(), 1'b1));
      end
      default: begin
        if (stack_fill == 0) begin
          owed_results.push_back(make_result(ST_EMPTY, '0, 1'b0, 1'b1));
        end else begin
          for (i = stack_fill - 1; i >= 0; i--)
            owed_results.push_back(make_result(ST_OK, stack_words[i], 1'b0, i == 0));
        end
      end
    endcase
  endtask

  // Offer one command after a random gap and wait for its transfer
  task automatic send_command(input command_t cmd, input logic [WW-1:0] value);
    lsp_in_t item;
    int      gap;
    item.command    = cmd;
    item.push_value = value;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= item;
    do @(posedge clk); while (!cmd_ready);
    predict_command(item);
  endtask

  task automatic empty_stack();
    while (stack_fill > 0) send_command(CMD_POP, pick_word());
  endtask

  // Match one result transfer against the oldest owed result
  task automatic check_result(input lsp_out_t got);
    lsp_out_t want;
    if (owed_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("cycle %0d: unexpected result status=%0d data=%h pal=%b fill=%0d last=%b",
                 cycle_count, got.status, got.data_word, got.is_palindrome,
                 got.fill_level, got.last);
    end else begin
      want = owed_results.pop_front();
      if (got.status !== want.status || got.data_word !== want.data_word ||
          got.is_palindrome !== want.is_palindrome ||
          got.fill_level !== want.fill_level || got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("cycle %0d: expected status=%0d data=%h pal=%b fill=%0d last=%b",
                   cycle_count, want.status, want.data_word, want.is_palindrome,
                   want.fill_level, want.last);
          $display("cycle %0d:   actual status=%0d data=%h pal=%b fill=%0d last=%b",
                   cycle_count, got.status, got.data_word, got.is_palindrome,
                   got.fill_level, got.last);
        end
      end
    end
  endtask

  // Count down a long receiver hold each time one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_ticket;
    end
  end

  // Receive results, stalling at random or while a hold runs
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) check_result(res_data);
      if (hold_left > 0) begin
        res_ready <= 1'b0;
      end else if (stall_left > 0) begin
        res_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        res_ready  <= 1'b1;
        stall_left <= pick_gap(rx_stalls_on);
      end
    end
  end

  // Empty and full corners, field extremes, every command
  task automatic test_directed_cases();
    tx_gaps_on = 1'b0;
    send_command(CMD_POP, 32'hDEAD_BEEF);
    send_command(CMD_DUMP, 32'hFFFF_FFFF);
    send_command(CMD_CHECK, 32'h0000_0000);
    send_command(CMD_PUSH, 32'h8000_0000);
    send_command(CMD_CHECK, 32'h1234_5678);
    send_command(CMD_PUSH, 32'h7FFF_FFFF);
    send_command(CMD_PUSH, 32'hFFFF_FFFF);
    send_command(CMD_PUSH, 32'h0000_0000);
    send_command(CMD_PUSH, 32'hAAAA_AAAA);
    send_command(CMD_PUSH, 32'h5555_5555);
    send_command(CMD_PUSH, 32'h0000_0001);
    send_command(CMD_PUSH, 32'h8000_0000);
    send_command(CMD_PUSH, 32'h1234_5678);
    send_command(CMD_CHECK, 32'h0000_0000);
    send_command(CMD_DUMP, 32'h5555_5555);
    empty_stack();
    send_command(CMD_POP, 32'hAAAA_AAAA);
  endtask

  // Random commands, weighted toward push so the stack fills and drains
  task automatic test_random_mix(input int n_items);
    int r;
    tx_gaps_on = 1'b1;
    rx_stalls_on <= 1'b1;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_command(CMD_PUSH, pick_word());
      else if (r < 65) send_command(CMD_POP, pick_word());
      else if (r < 85) send_command(CMD_CHECK, pick_word());
      else send_command(CMD_DUMP, pick_word());
    end
  endtask

  // Build symmetric contents, sometimes with one flipped bit, then check
  task automatic test_palindrome_runs(input int n_runs);
    logic [WW-1:0] words [DEPTH];
    int            len;
    int            k;
    int            i;
    repeat (n_runs) begin
      tx_gaps_on = 1'($urandom_range(0, 1));
      rx_stalls_on <= 1'($urandom_range(0, 1));
      empty_stack();
      len = $urandom_range(0, DEPTH);
      for (i = 0; i < len; i++) words[i] = pick_word();
      for (i = 0; i < len / 2; i++) words[len - 1 - i] = words[i];
      if (len >= 2 && $urandom_range(0, 99) < 40) begin
        k = $urandom_range(0, len - 1);
        if (2 * k + 1 != len) words[k] = words[k] ^ (WW'(1) << $urandom_range(0, WW - 1));
      end
      for (i = 0; i < len; i++) send_command(CMD_PUSH, words[i]);
      send_command(CMD_CHECK, pick_word());
      if ($urandom_range(0, 99) < 30) send_command(CMD_DUMP, pick_word());
      if ($urandom_range(0, 99) < 40) begin
        send_command(CMD_POP, pick_word());
        send_command(CMD_CHECK, pick_word());
      end
    end
  endtask

  // Hold the receiver off while full-stack dumps pile up behind it
  task automatic test_full_stall();
    int i;
    tx_gaps_on = 1'b0;
    hold_ticket <= hold_ticket + 1;
    for (i = 0; i < DEPTH; i++) send_command(CMD_PUSH, pick_word());
    repeat (3) send_command(CMD_DUMP, pick_word());
    send_command(CMD_CHECK, pick_word());
    send_command(CMD_PUSH, pick_word());
    send_command(CMD_POP, pick_word());
    send_command(CMD_POP, pick_word());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_mix(130);
    test_palindrome_runs(18);
    test_full_stall();
    test_random_mix(60);
    cmd_valid    <= 1'b0;
    rx_stalls_on <= 1'b0;
    while (owed_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0)
      $display("[lifo_stack_with_palindrome_check] OK");
    else
      $display("[lifo_stack_with_palindrome_check] ERROR");
    $finish;
  end

endmodule

### sim.f
hdl/lsp_pkg.sv
hdl/lsp_mem.sv
hdl/lifo_stack_with_palindrome_check.sv
tb/lifo_stack_with_palindrome_check_tb.sv
